>>> hdl/assert_macros.svh
// Assertion macros shared by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CFPB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cfpb assertion failed");

// Implication with a delayed consequent.
`define CFPB_ASSERT_IMP2(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("cfpb delayed assertion failed");

`endif

>>> hdl/cfpb_pkg.sv
// Types, constants and the CRC-8 step function of the framed packet builder.
`timescale 1ns / 1ps

package cfpb_pkg;

	// Frame format constants.
	localparam logic [7:0] CRC_POLY     = 8'hD5;
	localparam logic [7:0] HEADER_RESET = 8'hCC;
	localparam logic [3:0] MAX_PAYLOAD  = 4'd13;

	// Error codes carried with each result.
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_TOO_LONG = 2'd1;
	localparam logic [1:0] ERR_OUTSIDE  = 2'd2;

	// Results per item and the job queue between front and back.
	localparam int RES_MAX   = 3;
	localparam int RES_IDX_W = 2;
	localparam int JOB_DEPTH = 4;
	localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
	localparam int JOB_CNT_W = JOB_PTR_W + 1;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       opens_frame;
		logic       closes_frame;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_run;
		logic       frame_done;
		logic [1:0] error_code;
	} out_item_t;

	// All results caused by one accepted item, with the index of the final one.
	typedef struct packed {
		out_item_t [RES_MAX-1:0] res;
		logic [RES_IDX_W-1:0]    last;
	} job_t;

	// Handshake from front to queue.
	typedef struct packed {
		logic push;
		job_t job;
	} job_wr_t;

	// One byte through the CRC-8, MSB first.
	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// CRC after the reset header byte alone.
	localparam logic [7:0] HDR_CRC_RESET = crc8_feed(8'h00, HEADER_RESET);

endpackage

>>> hdl/crc8_framed_packet_builder_top.sv
// Top level of the CRC-8 framed packet builder.
// An accepted item's first result goes through the job queue, then the output register.
// Throughput: one item per cycle unless the queue is full; the output register moves one result
// per cycle while popped; an item of k results needs k pops; a four-deep queue absorbs bursts.
// Reset: asynchronous, active low; frame state and queues clear, header returns to 0xCC.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crc8_framed_packet_builder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  cfpb_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output cfpb_pkg::out_item_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);
	import cfpb_pkg::*;

	job_wr_t job_wr;
	job_t    head;
	logic    q_full;
	logic    q_empty;
	logic    rd;
	logic    accept;
	logic    res_err;
	logic    res_clean;

	// The header register may be written in any cycle.
	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push && !q_full;

	cfpb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.job_wr   (job_wr)
	);

	cfpb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_wr  (job_wr),
		.rd      (rd),
		.head    (head),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	cfpb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.rd      (rd),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	// Terms for the result checks below.
	assign res_err   = !empty && (result.error_code != ERR_NONE);
	assign res_clean = (result.out_byte == 8'h00) && !result.frame_done;

	// An error result carries no byte and never closes a frame.
	`CFPB_ASSERT_IMP(a_err_clean, res_err, res_clean)
	// The closing CRC is always the final result of its item.
	`CFPB_ASSERT_IMP(a_crc_last, !empty && result.frame_done, result.end_of_run)
	// A transfer into an idle block reaches the result side through the job queue and the output register.
	`CFPB_ASSERT_IMP2(a_idle_latency, push && !full && empty && q_empty, !empty)

endmodule

>>> hdl/cfpb_front.sv
// Front end: accepts items, tracks frame state and turns each item into a job.
`timescale 1ns / 1ps

module cfpb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  cfpb_pkg::in_item_t  item,
	input  logic                cfg_wr,
	input  logic [7:0]          cfg_data,
	output cfpb_pkg::job_wr_t   job_wr
);
	import cfpb_pkg::*;

	logic [7:0]           header_q;
	logic [7:0]           hdr_crc_q;
	logic [7:0]           crc_q;
	logic [3:0]           count_q;
	logic                 open_q;
	logic [7:0]           crc_upd;
	logic [7:0]           crc_n;
	logic [3:0]           count_n;
	logic                 open_n;
	logic [RES_IDX_W-1:0] n0;
	logic [RES_IDX_W-1:0] last;
	logic                 closing;
	job_t                 job;

	// One CRC step per item that carries a byte; an opening item starts from the stored header CRC.
	assign crc_upd = crc8_feed(item.opens_frame ? hdr_crc_q : crc_q, item.byte_value);

	// Classify the item and build its results.
	always_comb begin
		job     = '0;
		crc_n   = crc_q;
		count_n = count_q;
		open_n  = open_q;
		n0      = RES_IDX_W'(1);
		closing = 1'b0;
		if (item.opens_frame) begin
			job.res[0].out_byte = header_q;
			job.res[1].out_byte = item.byte_value;
			n0      = RES_IDX_W'(2);
			crc_n   = crc_upd;
			count_n = '0;
			open_n  = 1'b1;
			closing = item.closes_frame;
		end else if (!open_q) begin
			job.res[0].error_code = ERR_OUTSIDE;
		end else if (count_q >= MAX_PAYLOAD) begin
			job.res[0].error_code = ERR_TOO_LONG;
			closing = item.closes_frame;
		end else begin
			job.res[0].out_byte = item.byte_value;
			crc_n   = crc_upd;
			count_n = count_q + 4'd1;
			closing = item.closes_frame;
		end
		last = n0 - RES_IDX_W'(1);
		if (closing) begin
			job.res[n0].out_byte   = crc_n;
			job.res[n0].frame_done = 1'b1;
			last    = n0;
			open_n  = 1'b0;
			count_n = '0;
			crc_n   = '0;
		end
		job.res[last].end_of_run = 1'b1;
		job.last = last;
	end

	assign job_wr.push = accept;
	assign job_wr.job  = job;

	// Frame state and header register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= HEADER_RESET;
			hdr_crc_q <= HDR_CRC_RESET;
			crc_q     <= '0;
			count_q   <= '0;
			open_q    <= 1'b0;
		end else begin
			if (cfg_wr) begin
				header_q  <= cfg_data;
				hdr_crc_q <= crc8_feed(8'h00, cfg_data);
			end
			if (accept) begin
				crc_q   <= crc_n;
				count_q <= count_n;
				open_q  <= open_n;
			end
		end
	end

endmodule

>>> hdl/cfpb_queue.sv
// Short job queue that decouples the front end from the result emitter.
`timescale 1ns / 1ps

module cfpb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  cfpb_pkg::job_wr_t job_wr,
	input  logic              rd,
	output cfpb_pkg::job_t    head,
	output logic              q_full,
	output logic              q_empty
);
	import cfpb_pkg::*;

	job_t                 mem_q [JOB_DEPTH];
	logic [JOB_PTR_W-1:0] wr_ptr_q;
	logic [JOB_PTR_W-1:0] rd_ptr_q;
	logic [JOB_CNT_W-1:0] count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign q_full  = (count_q == JOB_CNT_W'(JOB_DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = job_wr.push && !q_full;
	assign do_rd   = rd && !q_empty;
	assign head    = mem_q[rd_ptr_q];

	// Job storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= job_wr.job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0
					: wr_ptr_q + JOB_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0
					: rd_ptr_q + JOB_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + JOB_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - JOB_CNT_W'(1);
			end
		end
	end

endmodule

>>> hdl/cfpb_back.sv
// Back end: walks the results of the head job into the output register.
`timescale 1ns / 1ps

module cfpb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  cfpb_pkg::job_t      head,
	input  logic                q_empty,
	output logic                rd,
	input  logic                pop,
	output logic                empty,
	output cfpb_pkg::out_item_t result
);
	import cfpb_pkg::*;

	logic [RES_IDX_W-1:0] idx_q;
	logic                 out_valid_q;
	out_item_t            result_q;
	logic                 load;
	logic                 last_res;

	// Load a new result when the output register is free or being taken.
	assign load     = !q_empty && (!out_valid_q || pop);
	assign last_res = (idx_q == head.last);
	assign rd       = load && last_res;
	assign empty    = !out_valid_q;
	assign result   = result_q;

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= head.res[idx_q];
		end
	end

	// Result index within the head job and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= last_res ? '0 : idx_q + RES_IDX_W'(1);
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
